/* hw/rtl/gtrcm_pkg.sv */
// Shared types, constants and mapping ROM for the gamepad to RC channel mapper.
`default_nettype none
package gtrcm_pkg;

  localparam int NumChannels = 16;
  localparam int ChanW       = 4;
  localparam int NumAxes     = 6;
  localparam int SelW        = 3;
  localparam int AxisW       = 16;
  localparam int InDataW     = 112;

  localparam logic [1:0] ModeGeneric = 2'd0;
  localparam logic [1:0] ModeWide    = 2'd1;
  localparam logic [1:0] ModeRc      = 2'd2;

  localparam logic [1:0] RegOutputMode = 2'd0;
  localparam logic [1:0] RegAxisInMin  = 2'd1;
  localparam logic [1:0] RegAxisInMax  = 2'd2;
  localparam logic [1:0] RegTrigThresh = 2'd3;

  localparam logic [15:0] SwUp   = 16'd1;
  localparam logic [15:0] SwDown = 16'd2;
  localparam logic [15:0] SwMid  = 16'd3;

  localparam logic [ChanW-1:0] ChDial   = ChanW'(4);
  localparam logic [ChanW-1:0] ChLeftSw = ChanW'(5);
  localparam logic [ChanW-1:0] ChRightSw = ChanW'(6);

  typedef enum logic [1:0] {
    KindNone,
    KindAxis,
    KindBtn
  } kind_e;

  typedef struct packed {
    kind_e                  kind;
    logic [SelW-1:0]        sel;
    logic signed [15:0]     a;
    logic signed [15:0]     b;
  } map_entry_t;

  typedef enum logic [1:0] {
    StIdle,
    StEval,
    StWait,
    StEmit
  } state_e;

  typedef enum logic [1:0] {
    MduIdle,
    MduMul,
    MduDiv
  } mdu_state_e;

  typedef struct packed {
    logic               start;
    logic signed [16:0] x_off;
    logic signed [16:0] span;
    logic signed [16:0] den;
  } mdu_req_t;

  typedef struct packed {
    logic               done;
    logic signed [32:0] quot;
  } mdu_rsp_t;

  function automatic map_entry_t rom_entry(input logic [1:0] mode, input logic [ChanW-1:0] ch);
    map_entry_t e;
    e = '{KindNone, SelW'(0), 16'sd1024, 16'sd1024};
    case (mode)
      ModeRc: begin
        case (ch)
          ChanW'(0): e = '{KindAxis, SelW'(2), 16'sd364, 16'sd1684};
          ChanW'(1): e = '{KindAxis, SelW'(3), 16'sd364, 16'sd1684};
          ChanW'(2): e = '{KindAxis, SelW'(1), 16'sd364, 16'sd1684};
          ChanW'(3): e = '{KindAxis, SelW'(0), 16'sd364, 16'sd1684};
          default:   e = '{KindNone, SelW'(0), 16'sd1024, 16'sd1024};
        endcase
      end
      ModeWide: begin
        if (ch < ChanW'(4)) begin
          e = '{KindAxis, SelW'(ch), -16'sd30000, 16'sd30000};
        end else if (ch < ChanW'(8)) begin
          e = '{KindBtn, SelW'(ch - ChanW'(4)), 16'sd1, 16'sd0};
        end
      end
      default: begin
        if (ch < ChanW'(4)) begin
          e = '{KindAxis, SelW'(ch), 16'sd200, 16'sd1800};
        end else if (ch < ChanW'(10)) begin
          e = '{KindBtn, SelW'(ch - ChanW'(4)), 16'sd1800, 16'sd200};
        end
      end
    endcase
    return e;
  endfunction

endpackage
`default_nettype wire

/* hw/rtl/gtrcm_mdu.sv */
// Shared multiply then shift-subtract divide unit, signed, truncating toward zero.
`default_nettype none
module gtrcm_mdu (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire gtrcm_pkg::mdu_req_t  req_i,
  output gtrcm_pkg::mdu_rsp_t       rsp_o
);

  gtrcm_pkg::mdu_state_e state_q, state_d;

  logic signed [16:0] a_q, b_q;
  logic [15:0]        dmag_q;
  logic               dneg_q;
  logic               neg_q;
  logic [31:0]        dvd_q;
  logic [15:0]        rem_q;
  logic [4:0]         cnt_q;
  logic               done_q;

  logic signed [33:0] prod;
  logic [31:0]        prod_mag;
  logic [16:0]        shifted;
  logic [16:0]        diff;
  logic               fits;

  assign prod     = a_q * b_q;
  assign prod_mag = prod[33] ? 32'(-prod) : prod[31:0];
  assign shifted  = {rem_q, dvd_q[31]};
  assign diff     = shifted - {1'b0, dmag_q};
  assign fits     = (shifted >= {1'b0, dmag_q});

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      gtrcm_pkg::MduIdle: if (req_i.start) state_d = gtrcm_pkg::MduMul;
      gtrcm_pkg::MduMul:  state_d = gtrcm_pkg::MduDiv;
      gtrcm_pkg::MduDiv:  if (cnt_q == 5'd31) state_d = gtrcm_pkg::MduIdle;
      default:            state_d = gtrcm_pkg::MduIdle;
    endcase
  end

  always_comb begin
    rsp_o.done = done_q;
    rsp_o.quot = neg_q ? -$signed({1'b0, dvd_q}) : $signed({1'b0, dvd_q});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= gtrcm_pkg::MduIdle;
      cnt_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= (state_q == gtrcm_pkg::MduDiv) && (cnt_q == 5'd31);
      if (state_q == gtrcm_pkg::MduDiv) begin
        cnt_q <= cnt_q + 5'd1;
      end else begin
        cnt_q <= '0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      gtrcm_pkg::MduIdle: begin
        if (req_i.start) begin
          a_q    <= req_i.x_off;
          b_q    <= req_i.span;
          dneg_q <= req_i.den[16];
          dmag_q <= req_i.den[16] ? 16'(-req_i.den) : req_i.den[15:0];
        end
      end
      gtrcm_pkg::MduMul: begin
        dvd_q <= prod_mag;
        rem_q <= '0;
        neg_q <= prod[33] ^ dneg_q;
      end
      gtrcm_pkg::MduDiv: begin
        rem_q <= fits ? diff[15:0] : shifted[15:0];
        dvd_q <= {dvd_q[30:0], fits};
      end
      default: ;
    endcase
  end

endmodule
`default_nettype wire

/* hw/rtl/gamepad_to_rc_channel_mapper.sv */
// Top level of the gamepad to RC channel mapper: sequencer, state and output register.
// Each accepted snapshot produces 16 channel transfers, channel 0 first, tlast on channel 15.
// A stick channel goes through the shared multiply-divide unit (a setup step, the
// multiply, 32 divide steps, loading the output register, then presenting the
// transfer); any other channel, and a stick channel when the input bounds are
// equal, skips the unit and is loaded into the output register directly. The
// input is not ready until the last channel of the frame has been transferred.
`default_nettype none
module gamepad_to_rc_channel_mapper (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          s_axis_tvalid,
  output logic               s_axis_tready,
  // left_x, left_y, right_x, right_y, left_trigger, right_trigger, button_mask
  input  wire logic [gtrcm_pkg::InDataW-1:0] s_axis_tdata,
  output logic               m_axis_tvalid,
  input  wire logic          m_axis_tready,
  // channel_value
  output logic [15:0]        m_axis_tdata,
  // channel_index
  output logic [3:0]         m_axis_tuser,
  output logic               m_axis_tlast,
  input  wire logic          cfg_valid_i,
  output logic               cfg_ready_o,
  input  wire logic [1:0]    cfg_index_i,
  input  wire logic [15:0]   cfg_data_i
);

  gtrcm_pkg::state_e state_q, state_d;

  logic [1:0]                     mode_q;
  logic signed [15:0]             in_min_q, in_max_q;
  logic [14:0]                    thr_q;
  logic signed [15:0]             axes_q [gtrcm_pkg::NumAxes];
  logic [7:0]                     btn_q;
  logic                           lmid_q, rmid_q, prevl_q, prevr_q;
  logic [gtrcm_pkg::ChanW-1:0]    ch_q;
  logic [15:0]                    out_val_q, out_val_d;

  gtrcm_pkg::map_entry_t          entry;
  gtrcm_pkg::mdu_req_t            mdu_req;
  gtrcm_pkg::mdu_rsp_t            mdu_rsp;

  logic                           in_xfer, out_xfer, cfg_xfer, last_ch;
  logic signed [16:0]             den;
  logic                           need_mdu;
  logic signed [15:0]             base_val, lo, hi, clamped, sel_val;
  logic signed [33:0]             r;
  logic                           lb, rb;
  logic                           ltrig, rtrig;
  logic [15:0]                    dial;
  logic                           load_out;

  assign in_xfer  = s_axis_tvalid && s_axis_tready;
  assign out_xfer = m_axis_tvalid && m_axis_tready;
  assign cfg_xfer = cfg_valid_i && cfg_ready_o;
  assign last_ch  = (ch_q == gtrcm_pkg::ChanW'(gtrcm_pkg::NumChannels - 1));
  assign lb       = s_axis_tdata[102];
  assign rb       = s_axis_tdata[103];

  assign entry    = gtrcm_pkg::rom_entry(mode_q, ch_q);
  assign den      = {in_max_q[15], in_max_q} - {in_min_q[15], in_min_q};
  assign need_mdu = (entry.kind == gtrcm_pkg::KindAxis) && (den != 17'sd0);

  always_comb begin
    mdu_req.start = (state_q == gtrcm_pkg::StEval) && need_mdu;
    mdu_req.x_off = {axes_q[entry.sel][15], axes_q[entry.sel]} - {in_min_q[15], in_min_q};
    mdu_req.span  = {entry.b[15], entry.b} - {entry.a[15], entry.a};
    mdu_req.den   = den;
  end

  gtrcm_mdu u_mdu (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mdu_req),
    .rsp_o  (mdu_rsp)
  );

  always_comb begin
    base_val = entry.a;
    if (entry.kind == gtrcm_pkg::KindBtn) begin
      base_val = btn_q[entry.sel] ? entry.a : entry.b;
    end
    lo = (entry.a < entry.b) ? entry.a : entry.b;
    hi = (entry.a < entry.b) ? entry.b : entry.a;
    r  = {mdu_rsp.quot[32], mdu_rsp.quot} + {{18{entry.a[15]}}, entry.a};
    if (r < $signed({{18{lo[15]}}, lo})) begin
      clamped = lo;
    end else if (r > $signed({{18{hi[15]}}, hi})) begin
      clamped = hi;
    end else begin
      clamped = r[15:0];
    end
  end

  assign ltrig = $signed({axes_q[4][15], axes_q[4]}) > $signed({2'b00, thr_q});
  assign rtrig = $signed({axes_q[5][15], axes_q[5]}) > $signed({2'b00, thr_q});

  always_comb begin
    if (btn_q[1]) dial = 16'd364;
    else if (btn_q[0]) dial = 16'd694;
    else if (btn_q[3]) dial = 16'd1684;
    else if (btn_q[2]) dial = 16'd1354;
    else dial = 16'd1024;
  end

  always_comb begin
    sel_val   = (state_q == gtrcm_pkg::StWait) ? clamped : base_val;
    out_val_d = sel_val;
    if (mode_q == gtrcm_pkg::ModeRc) begin
      if (ch_q == gtrcm_pkg::ChDial) begin
        out_val_d = dial;
      end else if (ch_q == gtrcm_pkg::ChLeftSw) begin
        out_val_d = lmid_q ? (ltrig ? gtrcm_pkg::SwUp : gtrcm_pkg::SwMid) : gtrcm_pkg::SwDown;
      end else if (ch_q == gtrcm_pkg::ChRightSw) begin
        out_val_d = rmid_q ? (rtrig ? gtrcm_pkg::SwUp : gtrcm_pkg::SwMid) : gtrcm_pkg::SwDown;
      end
    end
    load_out = ((state_q == gtrcm_pkg::StEval) && !need_mdu) ||
               ((state_q == gtrcm_pkg::StWait) && mdu_rsp.done);
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      gtrcm_pkg::StIdle: if (s_axis_tvalid) state_d = gtrcm_pkg::StEval;
      gtrcm_pkg::StEval: state_d = need_mdu ? gtrcm_pkg::StWait : gtrcm_pkg::StEmit;
      gtrcm_pkg::StWait: if (mdu_rsp.done) state_d = gtrcm_pkg::StEmit;
      gtrcm_pkg::StEmit: begin
        if (m_axis_tready) state_d = last_ch ? gtrcm_pkg::StIdle : gtrcm_pkg::StEval;
      end
      default: state_d = gtrcm_pkg::StIdle;
    endcase
  end

  always_comb begin
    s_axis_tready = (state_q == gtrcm_pkg::StIdle);
    m_axis_tvalid = (state_q == gtrcm_pkg::StEmit);
    m_axis_tdata  = out_val_q;
    m_axis_tuser  = ch_q;
    m_axis_tlast  = last_ch;
    cfg_ready_o   = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= gtrcm_pkg::StIdle;
      ch_q     <= '0;
      mode_q   <= gtrcm_pkg::ModeRc;
      in_min_q <= -16'sd32768;
      in_max_q <= 16'sd32767;
      thr_q    <= 15'd10000;
      lmid_q   <= 1'b0;
      rmid_q   <= 1'b0;
      prevl_q  <= 1'b0;
      prevr_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      if (in_xfer) begin
        ch_q    <= '0;
        lmid_q  <= lmid_q ^ (lb && !prevl_q);
        rmid_q  <= rmid_q ^ (rb && !prevr_q);
        prevl_q <= lb;
        prevr_q <= rb;
      end else if (out_xfer && !last_ch) begin
        ch_q <= ch_q + gtrcm_pkg::ChanW'(1);
      end
      if (cfg_xfer) begin
        unique case (cfg_index_i)
          gtrcm_pkg::RegOutputMode: mode_q   <= cfg_data_i[1:0];
          gtrcm_pkg::RegAxisInMin:  in_min_q <= cfg_data_i;
          gtrcm_pkg::RegAxisInMax:  in_max_q <= cfg_data_i;
          gtrcm_pkg::RegTrigThresh: thr_q    <= cfg_data_i[14:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      for (int i = 0; i < gtrcm_pkg::NumAxes; i++) begin
        axes_q[i] <= s_axis_tdata[i*gtrcm_pkg::AxisW +: gtrcm_pkg::AxisW];
      end
      btn_q <= s_axis_tdata[103:96];
    end
    if (load_out) begin
      out_val_q <= out_val_d;
    end
  end

endmodule
`default_nettype wire

/* hw/rtl/gtrcm_chk.sv */
// Port-level checker for the gamepad to RC channel mapper, bound to the top level.
`default_nettype none
module gtrcm_chk (
  input wire logic          clk_i,
  input wire logic          rst_ni,
  input wire logic          s_axis_tvalid,
  input wire logic          s_axis_tready,
  input wire logic [111:0]  s_axis_tdata,
  input wire logic          m_axis_tvalid,
  input wire logic          m_axis_tready,
  input wire logic [15:0]   m_axis_tdata,
  input wire logic [3:0]    m_axis_tuser,
  input wire logic          m_axis_tlast,
  input wire logic          cfg_valid_i,
  input wire logic          cfg_ready_o,
  input wire logic [1:0]    cfg_index_i,
  input wire logic [15:0]   cfg_data_i
);

  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(s_axis_tready && m_axis_tvalid))
    else $error("input ready while a channel transfer is pending");

  a_busy_after_in: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("input ready right after a snapshot transfer");

  a_last_on_final: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tlast == (m_axis_tuser == 4'(gtrcm_pkg::NumChannels - 1))))
    else $error("tlast does not match the final channel");

  a_frame_open: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tready && !m_axis_tlast) |=> !s_axis_tready)
    else $error("input ready before the frame ended");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=>
      (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)))
    else $error("stalled channel transfer changed");

endmodule

bind gamepad_to_rc_channel_mapper gtrcm_chk u_gtrcm_chk (.*);
`default_nettype wire
